[rtl/core/ccns_pkg.sv]
`default_nettype none
package ccns_pkg;

  localparam int COORD_W = 9;
  localparam int CFG_W   = 10;
  localparam int PIX_W   = 32;
  localparam int STAT_W  = 2;
  localparam int PROD_W  = COORD_W + CFG_W;
  localparam int CNT_W   = $clog2(PROD_W);
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int IN_DW   = 56;
  localparam int DIV3_SH = 16;

  localparam logic [15:0] DIV3_MUL = 16'd21846;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_TGT_W = 2'd2;
  localparam logic [1:0] REG_TGT_H = 2'd3;

  localparam logic [CFG_W-1:0] RST_SRC_W = 10'd512;
  localparam logic [CFG_W-1:0] RST_SRC_H = 10'd512;
  localparam logic [CFG_W-1:0] RST_TGT_W = 10'd128;
  localparam logic [CFG_W-1:0] RST_TGT_H = 10'd96;

  typedef struct packed {
    logic [CFG_W-1:0] src_w;
    logic [CFG_W-1:0] src_h;
    logic [CFG_W-1:0] tgt_w;
    logic [CFG_W-1:0] tgt_h;
  } cfg_t;

  typedef struct packed {
    logic mul;
    logic div_step;
    logic addr;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic div_last;
    logic out_busy;
  } stat_t;

  // floor(x/3), exact for 12-bit x
  function automatic logic [11:0] div3(input logic [11:0] x);
    logic [27:0] p;
    p = {16'd0, x} * {12'd0, DIV3_MUL};
    return p[DIV3_SH+11:DIV3_SH];
  endfunction

endpackage
`default_nettype wire

[rtl/core/center_crop_nearest_scaler_top.sv]
`default_nettype none
// channel | direction | payload
// in_     | slave     | tdata: coord_x, coord_y, pixel_in; tuser: mode
// out_    | master    | tdata: pixel_out; tuser: status
// cfg_    | apb slave | src_w 0x0, src_h 0x4, tgt_w 0x8, tgt_h 0xc
//
// Write beat: stored at the edge on which it is taken.
// Read beat: multiply, 19 restoring divider steps, address, registered frame
// store read, output load; a failed check goes straight to the output load.
// Synchronous active-low reset; the frame store is not cleared.
// A held result waits in the output register; the next beat is still taken.
module center_crop_nearest_scaler_top #(
  parameter int MAX_SOURCE_WIDTH  = 512,
  parameter int MAX_SOURCE_HEIGHT = 512
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // [8:0] coord_x, [17:9] coord_y, [49:18] pixel_in, [55:50] zero
  input  wire logic [ccns_pkg::IN_DW-1:0]  in_tdata,
  // [0] mode
  input  wire logic                        in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [31:0] pixel_out
  output logic      [ccns_pkg::PIX_W-1:0]  out_tdata,
  // [1:0] status
  output logic      [ccns_pkg::STAT_W-1:0] out_tuser,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [ccns_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [ccns_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [ccns_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import ccns_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;

  assign cfg_pready = 1'b1;
  assign in_fire    = in_tvalid & in_tready;

  ccns_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ccns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_mode  (in_tuser),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  ccns_dp #(
    .MAX_W (MAX_SOURCE_WIDTH),
    .MAX_H (MAX_SOURCE_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_fire    (in_fire),
    .in_mode    (in_tuser),
    .in_cx      (in_tdata[8:0]),
    .in_cy      (in_tdata[17:9]),
    .in_pix     (in_tdata[49:18]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pix    (out_tdata),
    .out_status (out_tuser)
  );

endmodule
`default_nettype wire

[rtl/core/ccns_regs.sv]
`default_nettype none
module ccns_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ccns_pkg::CFG_AW-1:0] paddr,
  input  wire logic [ccns_pkg::CFG_DW-1:0] pwdata,
  output logic      [ccns_pkg::CFG_DW-1:0] prdata,
  output ccns_pkg::cfg_t                   cfg
);
  import ccns_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign idx   = paddr[3:2];
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w <= RST_SRC_W;
      cfg_r.src_h <= RST_SRC_H;
      cfg_r.tgt_w <= RST_TGT_W;
      cfg_r.tgt_h <= RST_TGT_H;
    end else if (wr_en) begin
      case (idx)
        REG_SRC_W: cfg_r.src_w <= pwdata[CFG_W-1:0];
        REG_SRC_H: cfg_r.src_h <= pwdata[CFG_W-1:0];
        REG_TGT_W: cfg_r.tgt_w <= pwdata[CFG_W-1:0];
        REG_TGT_H: cfg_r.tgt_h <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_W: prdata = {{(CFG_DW-CFG_W){1'b0}}, cfg_r.src_w};
      REG_SRC_H: prdata = {{(CFG_DW-CFG_W){1'b0}}, cfg_r.src_h};
      REG_TGT_W: prdata = {{(CFG_DW-CFG_W){1'b0}}, cfg_r.tgt_w};
      REG_TGT_H: prdata = {{(CFG_DW-CFG_W){1'b0}}, cfg_r.tgt_h};
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/ccns_ctrl.sv]
`default_nettype none
module ccns_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          in_mode,
  input  ccns_pkg::stat_t    stat,
  output logic               in_ready,
  output ccns_pkg::cmd_t     cmd
);
  import ccns_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_mode == MODE_READ) begin
          state_nxt = stat.err ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/ccns_dp.sv]
`default_nettype none
module ccns_dp #(
  parameter int MAX_W = 512,
  parameter int MAX_H = 512
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  ccns_pkg::cfg_t                    cfg,
  input  ccns_pkg::cmd_t                    cmd,
  output ccns_pkg::stat_t                   stat,
  input  wire logic                         in_fire,
  input  wire logic                         in_mode,
  input  wire logic [ccns_pkg::COORD_W-1:0] in_cx,
  input  wire logic [ccns_pkg::COORD_W-1:0] in_cy,
  input  wire logic [ccns_pkg::PIX_W-1:0]   in_pix,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [ccns_pkg::PIX_W-1:0]   out_pix,
  output logic      [ccns_pkg::STAT_W-1:0]  out_status
);
  import ccns_pkg::*;

  localparam int DEPTH = MAX_W * MAX_H;
  localparam int AW    = $clog2(DEPTH);

  logic [PIX_W-1:0] mem [DEPTH];

  // crop window, recomputed from configuration every cycle
  logic [COORD_W-1:0] ox_r, oy_r;
  logic [CFG_W-1:0]   spx_r, spy_r;
  logic [COORD_W-1:0] ox_c, oy_c;
  logic [CFG_W-1:0]   spx_c, spy_c;

  always_comb begin
    logic [CFG_W-1:0] sat_w, sat_h;
    logic [11:0]      w3, h4, q3;
    logic [CFG_W-1:0] dif;
    sat_w = (32'(cfg.src_w) > MAX_W) ? CFG_W'(MAX_W) : cfg.src_w;
    sat_h = (32'(cfg.src_h) > MAX_H) ? CFG_W'(MAX_H) : cfg.src_h;
    w3    = {2'b00, sat_w} * 12'd3;
    h4    = {sat_h, 2'b00};
    q3    = div3(h4);
    ox_c  = '0;
    oy_c  = '0;
    spx_c = sat_w;
    spy_c = sat_h;
    dif   = '0;
    if (w3 > h4) begin
      spx_c = q3[CFG_W-1:0];
      dif   = sat_w - spx_c;
      ox_c  = dif[CFG_W-1:1];
    end else if (w3 < h4) begin
      spy_c = w3[11:2];
      dif   = sat_h - spy_c;
      oy_c  = dif[CFG_W-1:1];
    end
  end

  always_ff @(posedge clk) begin
    ox_r  <= ox_c;
    oy_r  <= oy_c;
    spx_r <= spx_c;
    spy_r <= spy_c;
  end

  // request checks on the accepted beat
  logic             cfg_zero, out_range;
  logic [STAT_W-1:0] chk_status;

  assign cfg_zero  = (cfg.src_w == '0) || (cfg.src_h == '0) ||
                     (cfg.tgt_w == '0) || (cfg.tgt_h == '0);
  assign out_range = ({1'b0, in_cx} >= cfg.tgt_w) || ({1'b0, in_cy} >= cfg.tgt_h);
  assign chk_status = cfg_zero ? ST_ZERO : (out_range ? ST_RANGE : ST_OK);
  assign stat.err   = (chk_status != ST_OK);

  // source pixel writes
  logic          wr_ok;
  logic [AW-1:0] wr_addr;

  assign wr_ok   = (32'(in_cx) < MAX_W) && (32'(in_cy) < MAX_H);
  assign wr_addr = AW'(32'(in_cy) * MAX_W + 32'(in_cx));

  always_ff @(posedge clk) begin
    if (in_fire && in_mode == MODE_WRITE && wr_ok) begin
      mem[wr_addr] <= in_pix;
    end
  end

  // read path
  logic [COORD_W-1:0] cx_r, cy_r;
  logic [STAT_W-1:0]  st_r;
  logic [PROD_W-1:0]  dqx_r, dqy_r;
  logic [CFG_W-1:0]   remx_r, remy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [AW-1:0]      rd_addr_r;
  logic [PIX_W-1:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (in_fire && in_mode == MODE_READ) begin
      cx_r <= in_cx;
      cy_r <= in_cy;
      st_r <= chk_status;
    end
  end

  // one restoring divider step, shared form for both axes
  function automatic logic [CFG_W+PROD_W-1:0] div_step(
    input logic [CFG_W-1:0]  rem,
    input logic [PROD_W-1:0] dq,
    input logic [CFG_W-1:0]  d
  );
    logic [CFG_W:0]   t;
    logic [CFG_W:0]   s;
    logic             q;
    t = {rem, dq[PROD_W-1]};
    s = t - {1'b0, d};
    q = (t >= {1'b0, d});
    return {q ? s[CFG_W-1:0] : t[CFG_W-1:0], dq[PROD_W-2:0], q};
  endfunction

  assign stat.div_last = (cnt_r == CNT_W'(PROD_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      dqx_r  <= {{(PROD_W-COORD_W){1'b0}}, cx_r} * {{(PROD_W-CFG_W){1'b0}}, spx_r};
      dqy_r  <= {{(PROD_W-COORD_W){1'b0}}, cy_r} * {{(PROD_W-CFG_W){1'b0}}, spy_r};
      remx_r <= '0;
      remy_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      {remx_r, dqx_r} <= div_step(remx_r, dqx_r, cfg.tgt_w);
      {remy_r, dqy_r} <= div_step(remy_r, dqy_r, cfg.tgt_h);
      cnt_r           <= cnt_r + 1'b1;
    end
  end

  logic [CFG_W:0] sx, sy;

  assign sx = {2'b00, ox_r} + {1'b0, dqx_r[CFG_W-1:0]};
  assign sy = {2'b00, oy_r} + {1'b0, dqy_r[CFG_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      rd_addr_r <= AW'(32'(sy) * MAX_W + 32'(sx));
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  // output register
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [STAT_W-1:0] out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix_r    <= (st_r == ST_OK) ? rd_data_r : '0;
      out_status_r <= st_r;
    end
  end

  assign stat.out_busy = out_valid_r & ~out_ready;
  assign out_valid     = out_valid_r;
  assign out_pix       = out_pix_r;
  assign out_status    = out_status_r;

endmodule
`default_nettype wire

[sim/tb_top.sv]
module tb_top;
  import ccns_pkg::*;

  localparam int STORE_W     = 512;
  localparam int STORE_H     = 512;
  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [STAT_W-1:0] status;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  wire  in_tready;
  logic [IN_DW-1:0] in_tdata;
  logic in_tuser;
  wire  out_tvalid;
  logic out_tready;
  wire  [PIX_W-1:0]  out_tdata;
  wire  [STAT_W-1:0] out_tuser;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  wire  [CFG_DW-1:0] cfg_prdata;
  wire  cfg_pready;

  center_crop_nearest_scaler_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scaler model state
  logic [CFG_W-1:0] src_w, src_h, tgt_w, tgt_h;
  int crop_ox, crop_oy, crop_wx, crop_wy;
  logic [PIX_W-1:0] frame_mem [int];
  pix_result_t pending_pixels [$];

  int  fail_count;
  int  beats_sent;
  int  reads_sent;
  int  results_seen;
  int  cfg_writes;
  bit  no_gaps;
  int  hold_req;

  function automatic void update_crop();
    int sw, sh;
    sw = (src_w > STORE_W) ? STORE_W : int'(src_w);
    sh = (src_h > STORE_H) ? STORE_H : int'(src_h);
    crop_ox = 0;
    crop_oy = 0;
    crop_wx = sw;
    crop_wy = sh;
    if (sw * 3 > sh * 4) begin
      crop_wx = (sh * 4) / 3;
      crop_ox = (sw - crop_wx) / 2;
    end else if (sw * 3 < sh * 4) begin
      crop_wy = (sw * 3) / 4;
      crop_oy = (sh - crop_wy) / 2;
    end
  endfunction

  function automatic logic [STAT_W-1:0] sample_target(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y,
                                                      output int addr);
    int sx, sy;
    addr = -1;
    if (src_w == 0 || src_h == 0 || tgt_w == 0 || tgt_h == 0) return ST_ZERO;
    if (x >= tgt_w || y >= tgt_h) return ST_RANGE;
    sx = crop_ox + (int'(x) * crop_wx) / int'(tgt_w);
    sy = crop_oy + (int'(y) * crop_wy) / int'(tgt_h);
    addr = sy * STORE_W + sx;
    return ST_OK;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 15) return 10'd1;
    if (r < 25) return 10'd512;
    if (r < 35) return CFG_W'($urandom_range(513, 1023));
    return CFG_W'($urandom_range(2, 511));
  endfunction

  task automatic send_beat(input logic mode, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix);
    int gap;
    int addr;
    pix_result_t want;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_DW - PIX_W - 2*COORD_W){1'b0}}, pix, y, x};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (mode == MODE_WRITE) begin
      frame_mem[int'(y) * STORE_W + int'(x)] = pix;
    end else begin
      reads_sent++;
      want.status = sample_target(x, y, addr);
      want.pixel  = (want.status == ST_OK) ? frame_mem[addr] : '0;
      pending_pixels.push_back(want);
    end
  endtask

  // a sampled source pixel is written first if it never was
  task automatic read_target(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int addr;
    if (sample_target(x, y, addr) == ST_OK && !frame_mem.exists(addr))
      send_beat(MODE_WRITE, COORD_W'(addr % STORE_W), COORD_W'(addr / STORE_W), $urandom());
    send_beat(MODE_READ, x, y, $urandom());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= {22'($urandom()), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_SRC_W: src_w = val;
      REG_SRC_H: src_h = val;
      REG_TGT_W: tgt_w = val;
      default:   tgt_h = val;
    endcase
    update_crop();
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                           input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
    drain();
    cfg_write(REG_SRC_W, sw);
    cfg_write(REG_SRC_H, sh);
    cfg_write(REG_TGT_W, tw);
    cfg_write(REG_TGT_H, th);
  endtask

  task automatic test_reset_sizes();
    send_beat(MODE_WRITE, 9'd0, 9'd0, 32'h0000_0000);
    send_beat(MODE_WRITE, 9'd511, 9'd511, 32'hFFFF_FFFF);
    read_target(9'd0, 9'd0);
    read_target(9'd127, 9'd95);
    read_target(9'd128, 9'd0);
    read_target(9'd0, 9'd96);
    read_target(9'd511, 9'd511);
  endtask

  task automatic test_crop_shapes();
    set_sizes(10'd400, 10'd300, 10'd4, 10'd3);
    read_target(9'd3, 9'd2);
    read_target(9'd0, 9'd0);
    set_sizes(10'd512, 10'd6, 10'd1, 10'd1);
    read_target(9'd0, 9'd0);
    read_target(9'd1, 9'd0);
    set_sizes(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    read_target(9'd511, 9'd511);
    read_target(9'd0, 9'd0);
  endtask

  task automatic test_zero_sizes();
    for (int r = 0; r < 4; r++) begin
      set_sizes((r == 0) ? 10'd0 : 10'd64, (r == 1) ? 10'd0 : 10'd48,
                (r == 2) ? 10'd0 : 10'd16, (r == 3) ? 10'd0 : 10'd12);
      send_beat(MODE_WRITE, 9'h155, 9'h0AA, 32'hA5A5_5A5A);
      read_target(9'd511, 9'd511);
    end
  endtask

  task automatic test_random_phase(input int phase);
    int xr, yr;
    set_sizes(pick_size(), pick_size(), pick_size(), pick_size());
    xr = (tgt_w == 0) ? STORE_W - 1 : ((tgt_w > STORE_W) ? STORE_W - 1 : int'(tgt_w) - 1);
    yr = (tgt_h == 0) ? STORE_H - 1 : ((tgt_h > STORE_H) ? STORE_H - 1 : int'(tgt_h) - 1);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      no_gaps = (phase % 2 == 1) && (i < 30);
      if ($urandom_range(0, 99) < 35)
        send_beat(MODE_WRITE, COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
      else if ($urandom_range(0, 99) < 85)
        read_target(COORD_W'($urandom_range(0, xr)), COORD_W'($urandom_range(0, yr)));
      else
        read_target(COORD_W'($urandom()), COORD_W'($urandom()));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_stall();
    set_sizes(10'd512, 10'd384, 10'd160, 10'd120);
    hold_req = 300;
    no_gaps  = 1'b1;
    for (int i = 0; i < 14; i++)
      read_target(COORD_W'($urandom_range(0, 159)), COORD_W'($urandom_range(0, 119)));
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin : sink
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: pixel %h status %0d", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata !== want.pixel || out_tuser !== want.status) begin
          if (fail_count < 10)
            $display("result %0d mismatch: pixel exp %h got %h, status exp %0d got %0d",
                     results_seen, want.pixel, out_tdata, want.status, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: %0d cycles without a beat, %0d results pending",
             STALL_LIMIT, pending_pixels.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= MODE_WRITE;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    fail_count   = 0;
    beats_sent   = 0;
    reads_sent   = 0;
    results_seen = 0;
    cfg_writes   = 0;
    no_gaps      = 1'b0;
    hold_req     = 0;
    src_w = RST_SRC_W;
    src_h = RST_SRC_H;
    tgt_w = RST_TGT_W;
    tgt_h = RST_TGT_H;
    update_crop();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_sizes();
    test_crop_shapes();
    test_zero_sizes();
    for (int p = 0; p < PHASES; p++)
      test_random_phase(p);
    test_output_stall();
    drain();

    $display("%0d beats sent (%0d reads), %0d results checked, %0d register writes",
             beats_sent, reads_sent, results_seen, cfg_writes);
    $display("covered crop shapes, saturated and zero sizes, range errors, output stalls");
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ccns_pkg.sv
rtl/core/ccns_regs.sv
rtl/core/ccns_ctrl.sv
rtl/core/ccns_dp.sv
rtl/core/center_crop_nearest_scaler_top.sv
sim/tb_top.sv
